>>> hw/rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Item types, command codes, result codes and fixed time constants.
// ----------------------------------------------------------------------------
package pts_pkg;

	// input item kinds
	localparam logic [2:0] KIND_REGISTER = 3'd0;
	localparam logic [2:0] KIND_ENABLE   = 3'd1;
	localparam logic [2:0] KIND_TICK     = 3'd2;
	localparam logic [2:0] KIND_OUTCOME  = 3'd3;
	localparam logic [2:0] KIND_DEADLINE = 3'd4;

	// classified operations
	localparam logic [2:0] OP_NOP      = 3'd0;
	localparam logic [2:0] OP_REGISTER = 3'd1;
	localparam logic [2:0] OP_ENABLE   = 3'd2;
	localparam logic [2:0] OP_TICK     = 3'd3;
	localparam logic [2:0] OP_OUTCOME  = 3'd4;
	localparam logic [2:0] OP_DEADLINE = 3'd5;

	// result kinds
	localparam logic [1:0] RK_ACK      = 2'd0;
	localparam logic [1:0] RK_RUN      = 2'd1;
	localparam logic [1:0] RK_TICKDONE = 2'd2;
	localparam logic [1:0] RK_DEADLINE = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOREG = 2'd2;

	// time constants
	localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
	localparam logic [19:0] NS_PER_MS    = 20'd1000000;
	localparam logic [31:0] IDLE_WAIT_MS = 32'd1000;
	localparam logic [31:0] WAIT_CAP     = 32'd2147483647;

	// waits at or above this many ns saturate to the cap
	localparam logic [63:0] CAP_NS = (64'(WAIT_CAP) + 64'd1) * 64'(NS_PER_MS);
	// ceil(2^59 / 15625): exact quotient for any 45-bit dividend
	localparam logic [45:0] MS_RECIP = 46'd36893488147420;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] now_ns;
		logic [3:0]  task_index;
		logic [30:0] period_s;
		logic        enable_flag;
		logic        failed;
	} req_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [1:0]        status;
		logic [3:0]        run_index;
		logic [4:0]        runs_this_tick;
		logic signed [31:0] deadline_ms;
		logic [63:0]       runs_total;
		logic [63:0]       errors_total;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] now_ns;
		logic [3:0]  task_index;
		logic [30:0] period_s;
		logic        enable_flag;
		logic        failed;
	} cmd_t;

endpackage

>>> hw/rtl/pts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler queue
// Small first-in first-out queue of registers with push/full and pop/empty.
// ----------------------------------------------------------------------------
module pts_fifo #(
	parameter int DEPTH = 2,
	parameter int W     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] data_in,
	output logic         empty,
	input  logic         pop,
	output logic [W-1:0] data_out
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/pts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler front end
// Accepts items, classifies their kind into an operation and queues them.
// ----------------------------------------------------------------------------
module pts_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  pts_pkg::req_t request,
	output logic          cmd_empty,
	input  logic          cmd_pop,
	output pts_pkg::cmd_t cmd
);
	import pts_pkg::*;

	cmd_t cmd_in;

	// classify item kind
	always_comb begin
		cmd_in.now_ns       = request.now_ns;
		cmd_in.task_index   = request.task_index;
		cmd_in.period_s     = request.period_s;
		cmd_in.enable_flag  = request.enable_flag;
		cmd_in.failed       = request.failed;
		case (request.kind)
			KIND_REGISTER: cmd_in.op = OP_REGISTER;
			KIND_ENABLE:   cmd_in.op = OP_ENABLE;
			KIND_TICK:     cmd_in.op = OP_TICK;
			KIND_OUTCOME:  cmd_in.op = OP_OUTCOME;
			KIND_DEADLINE: cmd_in.op = OP_DEADLINE;
			default:       cmd_in.op = OP_NOP;
		endcase
	end

	// command queue toward the back end
	pts_fifo #(
		.DEPTH(2),
		.W($bits(cmd_t))
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_in(cmd_in),
		.empty(cmd_empty),
		.pop(cmd_pop),
		.data_out(cmd)
	);

endmodule

>>> hw/rtl/pts_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler back end
// Holds the task table, walks it for ticks and deadline queries, scales the
// shortest wait down to milliseconds by a reciprocal multiply and produces
// result items.
// ----------------------------------------------------------------------------
module pts_exec #(
	parameter int MAX_TASKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  pts_pkg::cmd_t cmd,
	input  logic          rsp_full,
	output logic          rsp_push,
	output pts_pkg::rsp_t rsp
);
	import pts_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_DEC  = 4'd3;
	localparam logic [3:0] S_NEXT = 4'd4;
	localparam logic [3:0] S_FIN  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_EMIT = 4'd7;

	// task table
	logic [30:0] ivl_mem [MAX_TASKS];
	logic        en_mem  [MAX_TASKS];
	logic        hr_mem  [MAX_TASKS];
	logic [63:0] lr_mem  [MAX_TASKS];

	logic [3:0]  state_q;
	logic [3:0]  ret_q;
	logic [2:0]  op_q;
	logic [63:0] now_q;
	logic [IW-1:0] walk_q;
	logic [CW-1:0] count_q;
	logic [4:0]  runs_q;
	logic        any_q;
	logic [63:0] best_q;
	logic [63:0] run_total_q;
	logic [63:0] error_total_q;

	// result under construction
	logic [1:0]  res_kind_q;
	logic [1:0]  res_status_q;
	logic [3:0]  res_index_q;
	logic [4:0]  res_runs_q;
	logic [31:0] res_dl_q;
	logic        res_last_q;

	// walk pipeline
	logic [30:0] rd_ivl_s1;
	logic        rd_en_s1;
	logic        rd_hr_s1;
	logic [63:0] rd_lr_s1;
	logic [63:0] span_s2;
	logic [63:0] el_s2;
	logic        lt_s2;
	logic        en_s2;
	logic        hr_s2;

	// millisecond scaling: wait / 64 times the reciprocal of 15625
	logic [44:0] dy_q;
	logic [90:0] acc_q;
	logic [1:0]  div_cnt_q;

	logic [60:0] span_prod;
	logic [22:0] dy_lo;
	logic [22:0] dy_hi;
	logic [22:0] mul_a;
	logic [22:0] mul_b;
	logic [45:0] mul_prod;
	logic [90:0] pp_sh;
	logic [90:0] acc_nx;
	logic [63:0] wait_d;
	logic        tick_due;
	logic        dl_due;
	logic        idx_bad;
	logic [IW-1:0] idx_addr;
	logic [IW-1:0] cnt_addr;
	logic [IW+3:0] idx_wide;
	logic [CW+IW-1:0] cnt_wide;
	logic [IW+3:0] walk_wide;
	logic        walk_end;

	// memory write controls
	logic          we_reg;
	logic          we_en;
	logic          we_run;

	// address and index conversions
	assign idx_wide  = {{IW{1'b0}}, cmd.task_index};
	assign idx_addr  = idx_wide[IW-1:0];
	assign cnt_wide  = {{IW{1'b0}}, count_q};
	assign cnt_addr  = cnt_wide[IW-1:0];
	assign walk_wide = {4'b0, walk_q};
	assign idx_bad   = ({{CW{1'b0}}, cmd.task_index} >= {4'b0, count_q});
	assign walk_end  = ((CW'(walk_q) + 1'b1) == count_q);

	// per-entry arithmetic
	assign span_prod = 61'(rd_ivl_s1) * 61'(NS_PER_SEC);
	assign tick_due  = en_s2 && (!hr_s2 || (el_s2 >= span_s2));
	assign dl_due    = !hr_s2 || lt_s2 || (el_s2 >= span_s2);
	assign wait_d    = span_s2 - el_s2;

	// one 23x23 partial product per cycle, accumulated at its weight
	assign dy_lo = dy_q[22:0];
	assign dy_hi = {1'b0, dy_q[44:23]};

	always_comb begin
		case (div_cnt_q)
			2'd0: begin
				mul_a = dy_lo;
				mul_b = MS_RECIP[22:0];
			end
			2'd1: begin
				mul_a = dy_lo;
				mul_b = MS_RECIP[45:23];
			end
			2'd2: begin
				mul_a = dy_hi;
				mul_b = MS_RECIP[22:0];
			end
			default: begin
				mul_a = dy_hi;
				mul_b = MS_RECIP[45:23];
			end
		endcase
	end

	assign mul_prod = {23'b0, mul_a} * {23'b0, mul_b};

	always_comb begin
		case (div_cnt_q)
			2'd0:    pp_sh = {45'b0, mul_prod};
			2'd1:    pp_sh = {22'b0, mul_prod, 23'b0};
			2'd2:    pp_sh = {22'b0, mul_prod, 23'b0};
			default: pp_sh = {mul_prod[44:0], 46'b0};
		endcase
	end

	assign acc_nx = acc_q + pp_sh;

	// handshakes
	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign rsp_push = (state_q == S_EMIT) && !rsp_full;

	assign we_reg = cmd_pop && (cmd.op == OP_REGISTER) && (count_q < CW'(MAX_TASKS));
	assign we_en  = cmd_pop && (cmd.op == OP_ENABLE) && !idx_bad;
	assign we_run = (state_q == S_DEC) && (op_q == OP_TICK) && tick_due;

	// result item
	always_comb begin
		rsp.result_kind    = res_kind_q;
		rsp.status         = res_status_q;
		rsp.run_index      = res_index_q;
		rsp.runs_this_tick = res_runs_q;
		rsp.deadline_ms    = res_dl_q;
		rsp.runs_total     = run_total_q;
		rsp.errors_total   = error_total_q;
		rsp.last           = res_last_q;
	end

	// table writes
	always_ff @(posedge clk) begin
		if (we_reg) begin
			ivl_mem[cnt_addr] <= cmd.period_s;
			en_mem[cnt_addr]  <= cmd.enable_flag;
			hr_mem[cnt_addr]  <= 1'b0;
			lr_mem[cnt_addr]  <= '0;
		end else if (we_en) begin
			en_mem[idx_addr] <= cmd.enable_flag;
		end else if (we_run) begin
			hr_mem[walk_q] <= 1'b1;
			lr_mem[walk_q] <= now_q;
		end
	end

	// table reads, registered
	always_ff @(posedge clk) begin
		rd_ivl_s1 <= ivl_mem[walk_q];
		rd_en_s1  <= en_mem[walk_q];
		rd_hr_s1  <= hr_mem[walk_q];
		rd_lr_s1  <= lr_mem[walk_q];
	end

	// span and elapsed time
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			span_s2 <= 64'(span_prod);
			el_s2   <= now_q - rd_lr_s1;
			lt_s2   <= (now_q < rd_lr_s1);
			en_s2   <= rd_en_s1;
			hr_s2   <= rd_hr_s1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			op_q          <= OP_NOP;
			now_q         <= '0;
			walk_q        <= '0;
			count_q       <= '0;
			runs_q        <= '0;
			any_q         <= 1'b0;
			best_q        <= '0;
			run_total_q   <= '0;
			error_total_q <= '0;
			res_kind_q    <= RK_ACK;
			res_status_q  <= ST_OK;
			res_index_q   <= '0;
			res_runs_q    <= '0;
			res_dl_q      <= '0;
			res_last_q    <= 1'b0;
			dy_q          <= '0;
			acc_q         <= '0;
			div_cnt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						op_q         <= cmd.op;
						now_q        <= cmd.now_ns;
						walk_q       <= '0;
						runs_q       <= '0;
						any_q        <= 1'b0;
						res_kind_q   <= RK_ACK;
						res_status_q <= ST_OK;
						res_index_q  <= '0;
						res_runs_q   <= '0;
						res_dl_q     <= '0;
						res_last_q   <= 1'b1;
						ret_q        <= S_IDLE;
						state_q      <= S_EMIT;
						case (cmd.op)
							OP_REGISTER: begin
								if (we_reg) begin
									count_q <= count_q + 1'b1;
								end else begin
									res_status_q <= ST_FULL;
								end
							end
							OP_ENABLE: begin
								if (idx_bad) begin
									res_status_q <= ST_NOREG;
								end
							end
							OP_OUTCOME: begin
								if (idx_bad) begin
									res_status_q <= ST_NOREG;
								end else if (cmd.failed) begin
									error_total_q <= error_total_q + 1'b1;
								end
							end
							OP_TICK: begin
								state_q <= (count_q == '0) ? S_FIN : S_RD;
							end
							OP_DEADLINE: begin
								if (count_q == '0) begin
									res_kind_q <= RK_DEADLINE;
									res_dl_q   <= '1;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					state_q <= S_NEXT;
					if (op_q == OP_TICK) begin
						if (tick_due) begin
							run_total_q  <= run_total_q + 1'b1;
							runs_q       <= runs_q + 1'b1;
							res_kind_q   <= RK_RUN;
							res_status_q <= ST_OK;
							res_index_q  <= walk_wide[3:0];
							res_runs_q   <= '0;
							res_dl_q     <= '0;
							res_last_q   <= 1'b0;
							ret_q        <= S_NEXT;
							state_q      <= S_EMIT;
						end
					end else if (en_s2) begin
						if (dl_due) begin
							res_kind_q <= RK_DEADLINE;
							res_dl_q   <= '0;
							res_last_q <= 1'b1;
							ret_q      <= S_IDLE;
							state_q    <= S_EMIT;
						end else if (!any_q || (wait_d < best_q)) begin
							best_q <= wait_d;
							any_q  <= 1'b1;
						end
					end
				end
				S_NEXT: begin
					if (walk_end) begin
						state_q <= S_FIN;
					end else begin
						walk_q  <= walk_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					res_status_q <= ST_OK;
					res_index_q  <= '0;
					res_last_q   <= 1'b1;
					ret_q        <= S_IDLE;
					if (op_q == OP_TICK) begin
						res_kind_q <= RK_TICKDONE;
						res_runs_q <= runs_q;
						res_dl_q   <= '0;
						state_q    <= S_EMIT;
					end else begin
						res_kind_q <= RK_DEADLINE;
						res_runs_q <= '0;
						if (!any_q) begin
							res_dl_q <= IDLE_WAIT_MS;
							state_q  <= S_EMIT;
						end else if (best_q >= CAP_NS) begin
							res_dl_q <= WAIT_CAP;
							state_q  <= S_EMIT;
						end else begin
							// below the cap the wait fits in 51 bits
							dy_q      <= best_q[50:6];
							acc_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					acc_q     <= acc_nx;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 2'd3) begin
						res_dl_q <= acc_nx[90:59];
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (rsp_push) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TASKS))
		else $error("task count beyond table size");

	a_push_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push |-> (state_q == S_EMIT))
		else $error("result pushed outside emit state");

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q != S_IDLE))
		else $error("command taken but sequencer stayed idle");

	a_runs_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(run_total_q) |-> ($past(state_q) == S_DEC))
		else $error("run total moved outside a tick decision");

endmodule

>>> hw/rtl/periodic_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler
// Table of periodic tasks driven by register, enable, tick, outcome and
// deadline items, with a command queue in front and a result queue behind.
// ----------------------------------------------------------------------------
// A tick walks every registered entry and emits a run result for each due entry
// before its tick-done result. A deadline query stops at the first due entry;
// a reported wait goes through the reciprocal multiply. One item at a time
// in the back end. Reset clears the task count and both totals, no table pass.
module periodic_task_scheduler_unit #(
	parameter int MAX_TASKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  pts_pkg::req_t request,
	output logic          empty,
	input  logic          pop,
	output pts_pkg::rsp_t response
);
	import pts_pkg::*;

	cmd_t cmd;
	rsp_t rsp;
	logic cmd_empty;
	logic cmd_pop;
	logic rsp_full;
	logic rsp_push;

	// front end
	pts_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.cmd(cmd)
	);

	// back end
	pts_exec #(
		.MAX_TASKS(MAX_TASKS)
	) u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.rsp_full(rsp_full),
		.rsp_push(rsp_push),
		.rsp(rsp)
	);

	// result queue
	pts_fifo #(
		.DEPTH(2),
		.W($bits(rsp_t))
	) u_rsp_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(rsp_push),
		.full(rsp_full),
		.data_in(rsp),
		.empty(empty),
		.pop(pop),
		.data_out(response)
	);

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler testbench
// Drives register, enable, tick, outcome and deadline items through the
// input queue with random gaps, predicts every result from an independent
// model of the task table and checks each popped result field by field.
// ----------------------------------------------------------------------------
module testbench;
	import pts_pkg::*;

	localparam int NUM_TASKS = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam logic [63:0] SEC_NS = 64'd1000000000;
	localparam logic [63:0] MS_NS = 64'd1000000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	req_t request;
	logic empty;
	logic pop;
	rsp_t response;

	periodic_task_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.empty(empty), .pop(pop), .response(response)
	);

	// predicted task table
	logic [30:0] tbl_interval [NUM_TASKS];
	bit          tbl_enabled [NUM_TASKS];
	bit          tbl_has_run [NUM_TASKS];
	logic [63:0] tbl_stamp [NUM_TASKS];
	int          tbl_count;
	logic [63:0] pred_runs;
	logic [63:0] pred_errors;

	rsp_t result_q[$];
	int   mismatches;
	int   items_sent;
	int   results_seen;
	int   tick_items;
	bit   hold_request;
	bit   no_idle;
	logic [63:0] clock_ns;

	// directed table
	typedef struct {
		req_t item;
		bit   typed;
		rsp_t answer;
	} row_t;
	row_t rows[$];

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic rsp_t make_result(logic [1:0] rk, logic [1:0] st, logic [3:0] idx,
			logic [4:0] runs, logic signed [31:0] dl);
		rsp_t r;
		r.result_kind = rk;
		r.status = st;
		r.run_index = idx;
		r.runs_this_tick = runs;
		r.deadline_ms = dl;
		r.runs_total = pred_runs;
		r.errors_total = pred_errors;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic req_t make_item(logic [2:0] k, logic [63:0] t, logic [3:0] idx,
			logic [30:0] ivl, logic en, logic fl);
		req_t r;
		r.kind = k;
		r.now_ns = t;
		r.task_index = idx;
		r.period_s = ivl;
		r.enable_flag = en;
		r.failed = fl;
		return r;
	endfunction

	// scheduler prediction: append the results of one item
	function automatic void schedule_item(req_t r);
		rsp_t res[$];
		logic [63:0] span;
		logic [63:0] elapsed;
		logic [63:0] wait_ms;
		logic [63:0] best;
		logic [31:0] answer;
		bit any_wait;
		bit due;
		int runs;
		runs = 0;
		case (r.kind)
			KIND_REGISTER: begin
				if (tbl_count >= NUM_TASKS) begin
					res.push_back(make_result(RK_ACK, ST_FULL, 0, 0, 0));
				end else begin
					tbl_interval[tbl_count] = r.period_s;
					tbl_enabled[tbl_count] = r.enable_flag;
					tbl_has_run[tbl_count] = 1'b0;
					tbl_stamp[tbl_count] = '0;
					tbl_count++;
					res.push_back(make_result(RK_ACK, ST_OK, 0, 0, 0));
				end
			end
			KIND_ENABLE, KIND_OUTCOME: begin
				if (int'(r.task_index) >= tbl_count) begin
					res.push_back(make_result(RK_ACK, ST_NOREG, 0, 0, 0));
				end else begin
					if (r.kind == KIND_ENABLE)
						tbl_enabled[r.task_index] = r.enable_flag;
					else if (r.failed)
						pred_errors++;
					res.push_back(make_result(RK_ACK, ST_OK, 0, 0, 0));
				end
			end
			KIND_TICK: begin
				for (int i = 0; i < tbl_count; i++) begin
					span = 64'(tbl_interval[i]) * SEC_NS;
					if (tbl_enabled[i] &&
							(!tbl_has_run[i] || (r.now_ns - tbl_stamp[i]) >= span)) begin
						tbl_stamp[i] = r.now_ns;
						tbl_has_run[i] = 1'b1;
						pred_runs++;
						runs++;
						res.push_back(make_result(RK_RUN, ST_OK, 4'(i), 0, 0));
					end
				end
				res.push_back(make_result(RK_TICKDONE, ST_OK, 0, 5'(runs), 0));
			end
			KIND_DEADLINE: begin
				if (tbl_count == 0) begin
					answer = 32'hFFFF_FFFF;
				end else begin
					any_wait = 1'b0;
					due = 1'b0;
					best = '0;
					for (int i = 0; i < tbl_count && !due; i++) begin
						if (tbl_enabled[i]) begin
							span = 64'(tbl_interval[i]) * SEC_NS;
							elapsed = r.now_ns - tbl_stamp[i];
							if (!tbl_has_run[i] || r.now_ns < tbl_stamp[i] || elapsed >= span) begin
								due = 1'b1;
							end else begin
								wait_ms = (span - elapsed) / MS_NS;
								if (!any_wait || wait_ms < best)
									best = wait_ms;
								any_wait = 1'b1;
							end
						end
					end
					if (due)
						answer = 32'd0;
					else if (!any_wait)
						answer = 32'd1000;
					else
						answer = (best > 64'd2147483647) ? 32'd2147483647 : best[31:0];
				end
				res.push_back(make_result(RK_DEADLINE, ST_OK, 0, 0, answer));
			end
			default: begin
				res.push_back(make_result(RK_ACK, ST_OK, 0, 0, 0));
			end
		endcase
		res[res.size() - 1].last = 1'b1;
		foreach (res[i])
			result_q.push_back(res[i]);
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// hand one item to the block and wait until it is taken
	task automatic send(req_t r, int gap);
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		request = r;
		push = 1'b1;
		do @(posedge clk); while (full);
		items_sent++;
		if (r.kind == KIND_TICK)
			tick_items++;
	endtask

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	// random item, mostly well formed around a moving clock
	function automatic req_t random_item();
		int pick;
		logic [63:0] t;
		pick = $urandom_range(0, 99);
		clock_ns = clock_ns + 64'($urandom_range(0, 3000)) * MS_NS;
		t = clock_ns;
		if ($urandom_range(0, 19) == 0)
			t = {$urandom, $urandom};
		if (pick < 12)
			return make_item(KIND_REGISTER, {$urandom, $urandom}, 4'($urandom),
				($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 5)),
				($urandom_range(0, 3) != 0), 1'($urandom));
		else if (pick < 24)
			return make_item(KIND_ENABLE, {$urandom, $urandom}, 4'($urandom),
				31'($urandom), 1'($urandom), 1'($urandom));
		else if (pick < 58)
			return make_item(KIND_TICK, t, 4'($urandom), 31'($urandom), 1'($urandom),
				1'($urandom));
		else if (pick < 72)
			return make_item(KIND_OUTCOME, {$urandom, $urandom}, 4'($urandom),
				31'($urandom), 1'($urandom), 1'($urandom));
		else if (pick < 96)
			return make_item(KIND_DEADLINE, t, 4'($urandom), 31'($urandom), 1'($urandom),
				1'($urandom));
		else
			return make_item(3'($urandom_range(5, 7)), {$urandom, $urandom}, 4'($urandom),
				31'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	// result side: random stalls, one long hold on request, check each item
	initial begin
		rsp_t want;
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				pop = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			results_seen++;
			if (result_q.size() == 0) begin
				$display("mismatch at %0t: result with nothing expected", $realtime);
				mismatches++;
			end else begin
				want = result_q.pop_front();
				if (response.result_kind !== want.result_kind)
					report("result_kind", response.result_kind, want.result_kind);
				if (response.status !== want.status)
					report("status", response.status, want.status);
				if (response.run_index !== want.run_index)
					report("run_index", response.run_index, want.run_index);
				if (response.runs_this_tick !== want.runs_this_tick)
					report("runs_this_tick", response.runs_this_tick, want.runs_this_tick);
				if (response.deadline_ms !== want.deadline_ms)
					report("deadline_ms", response.deadline_ms, want.deadline_ms);
				if (response.runs_total !== want.runs_total)
					report("runs_total", response.runs_total, want.runs_total);
				if (response.errors_total !== want.errors_total)
					report("errors_total", response.errors_total, want.errors_total);
				if (response.last !== want.last)
					report("last", response.last, want.last);
			end
		end
	end

	// watchdog on cycles with no handshake
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog expired with %0d results pending", result_q.size());
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		row_t row;
		req_t item;
		push = 1'b0;
		request = '0;
		arst_n = 1'b0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		tick_items = 0;
		hold_request = 1'b0;
		no_idle = 1'b0;
		clock_ns = '0;
		tbl_count = 0;
		pred_runs = '0;
		pred_errors = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table answers, bad indexes, unknown kinds
		rows.push_back('{make_item(KIND_DEADLINE, 64'd0, 0, 0, 0, 0), 1,
			make_result(RK_DEADLINE, ST_OK, 0, 0, -32'sd1)});
		rows.push_back('{make_item(KIND_TICK, '1, 0, 0, 0, 0), 1,
			make_result(RK_TICKDONE, ST_OK, 0, 0, 0)});
		rows.push_back('{make_item(KIND_ENABLE, 0, 4'd0, 0, 1, 0), 1,
			make_result(RK_ACK, ST_NOREG, 0, 0, 0)});
		rows.push_back('{make_item(KIND_OUTCOME, 0, 4'd15, 0, 0, 1), 1,
			make_result(RK_ACK, ST_NOREG, 0, 0, 0)});
		rows.push_back('{make_item(3'd5, '1, 4'd15, '1, 1, 1), 1,
			make_result(RK_ACK, ST_OK, 0, 0, 0)});
		rows.push_back('{make_item(3'd6, 0, 0, 0, 0, 0), 1, make_result(RK_ACK, ST_OK, 0, 0, 0)});
		rows.push_back('{make_item(3'd7, '1, 4'd7, 0, 0, 1), 1,
			make_result(RK_ACK, ST_OK, 0, 0, 0)});
		// zero interval, largest interval, disabled entry
		rows.push_back('{make_item(KIND_REGISTER, 0, 0, 31'd0, 1, 0), 0, '0});
		rows.push_back('{make_item(KIND_REGISTER, 0, 0, '1, 1, 0), 0, '0});
		rows.push_back('{make_item(KIND_REGISTER, 0, 0, 31'd1, 0, 0), 0, '0});
		// never run is due, then runs stamped at time zero
		rows.push_back('{make_item(KIND_DEADLINE, 64'd0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_TICK, 64'd0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_TICK, 64'd0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_DEADLINE, 64'd0, 0, 0, 0, 0), 0, '0});
		// saturated wait once the zero interval entry is off
		rows.push_back('{make_item(KIND_ENABLE, 0, 4'd0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_DEADLINE, 64'd1, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_ENABLE, 0, 4'd1, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_DEADLINE, 64'd5, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_ENABLE, 0, 4'd2, 0, 1, 0), 0, '0});
		rows.push_back('{make_item(KIND_OUTCOME, 0, 4'd0, 0, 0, 1), 0, '0});
		rows.push_back('{make_item(KIND_OUTCOME, 0, 4'd1, 0, 0, 0), 0, '0});
		// clock far ahead, then behind the last run
		rows.push_back('{make_item(KIND_TICK, '1, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_ENABLE, 0, 4'd1, 0, 1, 0), 0, '0});
		rows.push_back('{make_item(KIND_DEADLINE, 64'd5, 0, 0, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_TICK, 64'd5, 0, 0, 0, 0), 0, '0});

		foreach (rows[i]) begin
			row = rows[i];
			send(row.item, draw_gap());
			schedule_item(row.item);
			if (row.typed) begin
				row.answer.last = 1'b1;
				result_q[result_q.size() - 1] = row.answer;
			end
		end

		// random traffic with idling on both sides
		repeat (110) begin
			item = random_item();
			send(item, draw_gap());
			schedule_item(item);
		end

		// long receiver hold while the sender keeps pushing
		hold_request = 1'b1;
		repeat (60) begin
			item = random_item();
			send(item, 0);
			schedule_item(item);
		end

		// sender pauses until everything has come back
		@(negedge clk);
		push = 1'b0;
		wait (result_q.size() == 0);

		// back to back on both sides
		no_idle = 1'b1;
		repeat (50) begin
			item = random_item();
			send(item, 0);
			schedule_item(item);
		end
		no_idle = 1'b0;

		repeat (80) begin
			item = random_item();
			send(item, draw_gap());
			schedule_item(item);
		end

		@(negedge clk);
		push = 1'b0;
		wait (result_q.size() == 0);
		repeat (200) @(posedge clk);

		$display("covered %0d items (%0d ticks), checked %0d results", items_sent,
			tick_items, results_seen);
		$display("table held %0d tasks, %0d runs and %0d errors counted, %0d mismatches",
			tbl_count, pred_runs, pred_errors, mismatches);
		if (mismatches == 0 && result_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
